@@ design/baro_pkg.sv @@
package baro_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned RawW  = 24;
  localparam int unsigned TempW = 16;
  localparam int unsigned PresW = 17;
  localparam int unsigned IdxW  = 4;

  localparam logic [DataW-1:0] B6Offset  = 32'd4000;
  localparam logic [DataW-1:0] B4Offset  = 32'd32768;
  localparam logic [DataW-1:0] PresBase  = 32'd50000;
  localparam logic [DataW-1:0] PresC1    = 32'd3038;
  localparam logic [DataW-1:0] PresC2    = 32'hFFFF_E343;  // -7357
  localparam logic [DataW-1:0] PresC3    = 32'd3791;
  localparam logic [PresW-1:0] PresMax   = 17'h1FFFF;

  typedef enum logic [IdxW-1:0] {
    REG_AC1     = 4'd0,
    REG_AC2     = 4'd1,
    REG_AC3     = 4'd2,
    REG_AC4     = 4'd3,
    REG_AC5_AC6 = 4'd4,
    REG_B1_B2   = 4'd5,
    REG_MC_MD   = 4'd6,
    REG_OSS     = 4'd7
  } reg_idx_t;

  typedef enum logic {
    CMD_TEMP = 1'b0,
    CMD_PRES = 1'b1
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_T_MUL,
    ST_T_DEN,
    ST_T_DIV,
    ST_T_FIN,
    ST_P_SQ,
    ST_P_X1A,
    ST_P_X2A,
    ST_P_B3,
    ST_P_X1B,
    ST_P_X2B,
    ST_P_X3,
    ST_P_B4,
    ST_P_B7,
    ST_P_CHK,
    ST_P_DIV,
    ST_P_SQP,
    ST_P_M1,
    ST_P_M2,
    ST_P_FIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DataW-1:0] quotient;
  } div_rsp_t;

  function automatic logic [DataW-1:0] asr(input logic [DataW-1:0] x, input int unsigned n);
    logic signed [DataW-1:0] s;
    s = $signed(x) >>> n;
    return s;
  endfunction

  function automatic logic [DataW-1:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

@@ design/baro_div.sv @@
module baro_div
  import baro_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DataW-1:0] rem_r, rem_nxt;
  logic [DataW-1:0] quo_r, quo_nxt;
  logic [DataW-1:0] den_r;
  logic [4:0]       cnt_r;
  logic             busy_r, done_r;
  logic [DataW:0]   trial;
  logic [DataW:0]   diff;

  // one restoring step per cycle, dividend bits shift out as quotient bits shift in
  always_comb begin
    trial = {rem_r, quo_r[DataW-1]};
    diff  = trial - {1'b0, den_r};
    if (!diff[DataW]) begin
      rem_nxt = diff[DataW-1:0];
      quo_nxt = {quo_r[DataW-2:0], 1'b1};
    end else begin
      rem_nxt = trial[DataW-1:0];
      quo_nxt = {quo_r[DataW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      den_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("divider done without a run");
  a_busy_len: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r != 5'd31 |=> busy_r)
    else $error("divider stopped early");

endmodule

@@ design/barometer_compensation.sv @@
// Channel | Dir | Fields (low bit first)                              | Accept
// in_     | in  | tuser: cmd; tdata: raw_value[23:0]                  | tvalid & tready
// out_    | out | tuser: result_kind, error; tdata: temp[15:0], pres  | tvalid & tready
// cfg_    | in  | index, wdata[31:0]                                   | wr_en
// A temperature or pressure word shows on out_ after accept; one shared 32x32 multiplier
// does the products and the 32-step serial divider does the one division of each word.
// A zero divisor ends the run early with the error bit set.
// in_tready is high only in the idle state; a new word may enter while a result waits.
// Reset is synchronous, active low; it clears calibration, B5 and all control state.
// Output stalls hold the finished result; the sequencer waits until the output register is free.
module barometer_compensation
  import baro_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [RawW-1:0]     in_tdata,   // raw_value[23:0]
  input  logic                in_tuser,   // cmd
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [39:0]         out_tdata,  // temperature_tenths[15:0], pressure_pa[32:16], pad
  output logic [1:0]          out_tuser,  // result_kind[0], error[1]
  input  logic                cfg_wr_en,
  input  logic [IdxW-1:0]     cfg_index,
  input  logic [DataW-1:0]    cfg_wdata
);

  logic [15:0]      ac1_r, ac2_r, ac3_r, ac4_r;
  logic [DataW-1:0] ac56_r, b12_r, mcmd_r;
  logic [1:0]       oss_r;

  state_t           state_r, state_nxt;
  logic             kind_r, err_r, neg_r;
  logic [DataW-1:0] a_r, x1_r, t_r, b6_r, sq_r, b3_r, add_r, b4_r, b7_r, p_r, ti_r;
  logic [RawW-1:0]  up_r;
  logic [TempW-1:0] temp_r;
  logic [PresW-1:0] pres_r;
  logic             out_valid_r;
  logic [TempW-1:0] out_temp_r;
  logic [PresW-1:0] out_pres_r;
  logic             out_kind_r, out_err_r;

  logic [DataW-1:0] mul_a, mul_b, prod;
  logic [DataW-1:0] den, mc_num, tsum, tval, b3sum, b3sh, pfin;
  logic [DataW-1:0] quo_s;
  logic             in_acc, out_free;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac1_r <= '0; ac2_r <= '0; ac3_r <= '0; ac4_r <= '0;
      ac56_r <= '0; b12_r <= '0; mcmd_r <= '0; oss_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_AC1:     ac1_r  <= cfg_wdata[15:0];
        REG_AC2:     ac2_r  <= cfg_wdata[15:0];
        REG_AC3:     ac3_r  <= cfg_wdata[15:0];
        REG_AC4:     ac4_r  <= cfg_wdata[15:0];
        REG_AC5_AC6: ac56_r <= cfg_wdata;
        REG_B1_B2:   b12_r  <= cfg_wdata;
        REG_MC_MD:   mcmd_r <= cfg_wdata;
        REG_OSS:     oss_r  <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = (in_tuser == CMD_TEMP) ? ST_T_MUL : ST_P_SQ;
      ST_T_MUL: state_nxt = ST_T_DEN;
      ST_T_DEN: state_nxt = (den == '0) ? ST_DONE : ST_T_DIV;
      ST_T_DIV: if (div_rsp.done) state_nxt = ST_T_FIN;
      ST_T_FIN: state_nxt = ST_DONE;
      ST_P_SQ:  state_nxt = ST_P_X1A;
      ST_P_X1A: state_nxt = ST_P_X2A;
      ST_P_X2A: state_nxt = ST_P_B3;
      ST_P_B3:  state_nxt = ST_P_X1B;
      ST_P_X1B: state_nxt = ST_P_X2B;
      ST_P_X2B: state_nxt = ST_P_X3;
      ST_P_X3:  state_nxt = ST_P_B4;
      ST_P_B4:  state_nxt = ST_P_B7;
      ST_P_B7:  state_nxt = ST_P_CHK;
      ST_P_CHK: state_nxt = (b4_r == '0) ? ST_DONE : ST_P_DIV;
      ST_P_DIV: if (div_rsp.done) state_nxt = ST_P_SQP;
      ST_P_SQP: state_nxt = ST_P_M1;
      ST_P_M1:  state_nxt = ST_P_M2;
      ST_P_M2:  state_nxt = ST_P_FIN;
      ST_P_FIN: state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // operand select for the shared multiplier and the divider launch
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    in_tready = (state_r == ST_IDLE);
    unique case (state_r)
      ST_T_MUL: begin mul_a = a_r;  mul_b = {16'b0, ac56_r[31:16]}; end
      ST_T_DEN: begin
        div_req.start    = (den != '0);
        div_req.dividend = mcmd_r[31] ? -mc_num : mc_num;
        div_req.divisor  = den[31] ? -den : den;
      end
      ST_P_SQ:  begin mul_a = b6_r; mul_b = b6_r; end
      ST_P_X1A: begin mul_a = sx16(b12_r[15:0]); mul_b = sq_r; end
      ST_P_X2A: begin mul_a = sx16(ac2_r); mul_b = b6_r; end
      ST_P_X1B: begin mul_a = sx16(ac3_r); mul_b = b6_r; end
      ST_P_X2B: begin mul_a = sx16(b12_r[31:16]); mul_b = sq_r; end
      ST_P_B4:  begin mul_a = {16'b0, ac4_r}; mul_b = add_r; end
      ST_P_B7:  begin mul_a = a_r; mul_b = PresBase >> oss_r; end
      ST_P_CHK: begin
        div_req.start    = (b4_r != '0);
        div_req.dividend = b7_r[31] ? b7_r : {b7_r[30:0], 1'b0};
        div_req.divisor  = b4_r;
      end
      ST_P_SQP: begin mul_a = asr(p_r, 8); mul_b = asr(p_r, 8); end
      ST_P_M1:  begin mul_a = x1_r; mul_b = PresC1; end
      ST_P_M2:  begin mul_a = PresC2; mul_b = p_r; end
      default: ;
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign den    = x1_r + sx16(mcmd_r[15:0]);
  assign mc_num = {{5{mcmd_r[31]}}, mcmd_r[31:16], 11'b0};
  assign quo_s  = neg_r ? -div_rsp.quotient : div_rsp.quotient;
  assign tsum   = ti_r + 32'd8;
  assign tval   = asr(tsum, 4);
  assign b3sum  = (sx16(ac1_r) << 2) + x1_r + t_r;
  assign b3sh   = b3sum << oss_r;
  assign pfin   = p_r + asr(x1_r + t_r + PresC3, 4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ti_r <= '0;
    end else if (state_r == ST_T_DIV && div_rsp.done) begin
      ti_r <= x1_r + quo_s;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        kind_r <= in_tuser;
        err_r  <= 1'b0;
        temp_r <= '0;
        pres_r <= '0;
        a_r    <= {16'b0, in_tdata[15:0]} - {16'b0, ac56_r[15:0]};
        b6_r   <= ti_r - B6Offset;
        up_r   <= in_tdata >> (4'd8 - {2'b00, oss_r});
      end
      ST_T_MUL: x1_r <= asr(prod, 15);
      ST_T_DEN: begin
        err_r <= (den == '0);
        neg_r <= mcmd_r[31] ^ den[31];
      end
      ST_T_FIN: begin
        if ($signed(tval) > 32'sd32767)       temp_r <= 16'h7FFF;
        else if ($signed(tval) < -32'sd32768) temp_r <= 16'h8000;
        else                                  temp_r <= tval[15:0];
      end
      ST_P_SQ:  sq_r <= asr(prod, 12);
      ST_P_X1A: x1_r <= asr(prod, 11);
      ST_P_X2A: t_r  <= asr(prod, 11);
      ST_P_B3:  b3_r <= asr(b3sh + 32'd2, 2);
      ST_P_X1B: x1_r <= asr(prod, 13);
      ST_P_X2B: t_r  <= asr(prod, 16);
      ST_P_X3:  add_r <= asr(x1_r + t_r + 32'd2, 2) + B4Offset;
      ST_P_B4: begin
        b4_r <= prod >> 15;
        a_r  <= {8'b0, up_r} - b3_r;
      end
      ST_P_B7:  b7_r <= prod;
      ST_P_CHK: err_r <= (b4_r == '0);
      ST_P_DIV: if (div_rsp.done) begin
        p_r <= b7_r[31] ? {div_rsp.quotient[30:0], 1'b0} : div_rsp.quotient;
      end
      ST_P_SQP: x1_r <= prod;
      ST_P_M1:  x1_r <= asr(prod, 16);
      ST_P_M2:  t_r  <= asr(prod, 16);
      ST_P_FIN: begin
        if (pfin[31])                            pres_r <= '0;
        else if (pfin > {15'b0, PresMax})        pres_r <= PresMax;
        else                                     pres_r <= pfin[PresW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_tready)                out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_kind_r <= kind_r;
      out_err_r  <= err_r;
      out_temp_r <= temp_r;
      out_pres_r <= pres_r;
    end
  end

  baro_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_pres_r, out_temp_r};
  assign out_tuser  = {out_err_r, out_kind_r};

  a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider launched while busy");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != ST_IDLE)
    else $error("sequencer stayed idle after accept");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_err_r |-> out_temp_r == '0 && out_pres_r == '0)
    else $error("error result carries data");
  a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_kind_r == CMD_TEMP && out_pres_r == '0) ||
                   (out_kind_r == CMD_PRES && out_temp_r == '0))
    else $error("unused result field not zero");

endmodule
